>>> hdl/fcv_pkg.sv
package fcv_pkg;

  // Sizes of the list
  localparam int FCV_CAPACITY = 1024;
  localparam int FCV_DATA_W   = 32;

  // Word returned by a failed remove or read
  localparam logic signed [FCV_DATA_W-1:0] FCV_FAIL_DATA = '1;

  // Operation codes carried by each command
  typedef enum logic [1:0] {
    OP_APPEND      = 2'd0,
    OP_REMOVE_LAST = 2'd1,
    OP_READ        = 2'd2,
    OP_DELETE      = 2'd3
  } op_t;

  // Command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_ROTATE = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_APPEND = 2'd3
  } cell_cmd_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_ROTATE = 2'd1,
    ST_DONE   = 2'd2
  } state_t;

endpackage

>>> hdl/fcv_cell.sv
module fcv_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 10,
  parameter int CNT_W = 11
) (
  input  logic                                    clk,
  input  fcv_pkg::cell_cmd_t                      cmd,
  input  logic [IDX_W-1:0]                        pos,
  input  logic [IDX_W-1:0]                        last,
  input  logic [CNT_W-1:0]                        count,
  input  logic signed [fcv_pkg::FCV_DATA_W-1:0]   wr_data,
  input  logic signed [fcv_pkg::FCV_DATA_W-1:0]   next_data,
  input  logic signed [fcv_pkg::FCV_DATA_W-1:0]   head_data,
  output logic signed [fcv_pkg::FCV_DATA_W-1:0]   data
);
  import fcv_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

  logic signed [FCV_DATA_W-1:0] data_next;

  // Pick this cell's next word from its neighbor, the head or the input
  always_comb begin
    data_next = data;
    unique case (cmd)
      CMD_HOLD: begin
        data_next = data;
      end
      CMD_ROTATE: begin
        // occupied cells move one place toward the front, the last wraps the head
        if (MY_IDX < last) begin
          data_next = next_data;
        end else if (MY_IDX == last) begin
          data_next = head_data;
        end
      end
      CMD_DELETE: begin
        // close the gap behind the dropped word
        if (MY_IDX >= pos && MY_IDX < last) begin
          data_next = next_data;
        end
      end
      CMD_APPEND: begin
        if (MY_CNT == count) begin
          data_next = wr_data;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

>>> hdl/fixed_capacity_vector.sv
// Fixed-capacity ordered list of signed 32-bit words, held one word per cell
// in a chain of CAPACITY cells. Append and delete act on all cells at once:
// the cells are written at the accepting edge and the result is then loaded
// from the done state; a delete moves every later word one cell toward the
// front at the accepting edge. Read and remove-last rotate the occupied cells
// through the head cell, one place per cycle, and pick off the wanted word as
// it passes; the rotation stops once every occupied word has passed the head,
// so the order is restored. The block works on one command at a time; a
// finished result sits in an output register so the next command can be
// accepted while the result waits.
// Failed operations return done_ok low and leave the list unchanged.
module fixed_capacity_vector #(
  parameter int CAPACITY = fcv_pkg::FCV_CAPACITY
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cmd_valid,
  output logic                                   cmd_ready,
  input  logic [1:0]                             opcode,
  input  logic signed [fcv_pkg::FCV_DATA_W-1:0]  item_value,
  input  logic [$clog2(CAPACITY)-1:0]            position,
  output logic                                   rsp_valid,
  input  logic                                   rsp_ready,
  output logic signed [fcv_pkg::FCV_DATA_W-1:0]  read_data,
  output logic                                   done_ok,
  output logic [$clog2(CAPACITY+1)-1:0]          item_count
);
  import fcv_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic signed [FCV_DATA_W-1:0] cell_data [CAPACITY];
  logic signed [FCV_DATA_W-1:0] head_data;

  state_t    state, state_next;
  cell_cmd_t cell_cmd;

  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] count_dec;
  logic [IDX_W-1:0] step, step_next;
  logic [IDX_W-1:0] target, target_next;
  logic [IDX_W-1:0] last;
  logic             pop, pop_next;
  logic signed [FCV_DATA_W-1:0] res_data, res_data_next;
  logic             res_ok, res_ok_next;
  logic             load_out;

  assign head_data = cell_data[0];
  assign last      = count_dec[IDX_W-1:0];

  assign count_dec = count - CNT_W'(1);

  // Chain of cells, each fed by its successor and the end cell by the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [FCV_DATA_W-1:0] nbr;
    if (i == CAPACITY - 1) begin : g_end
      assign nbr = head_data;
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end
    fcv_cell #(
      .INDEX (i),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cell_cmd),
      .pos       (position),
      .last      (last),
      .count     (count),
      .wr_data   (item_value),
      .next_data (nbr),
      .head_data (head_data),
      .data      (cell_data[i])
    );
  end

  // Sequencer: next state, cell command and result
  always_comb begin
    state_next    = state;
    count_next    = count;
    step_next     = step;
    target_next   = target;
    pop_next      = pop;
    res_data_next = res_data;
    res_ok_next   = res_ok;
    cell_cmd      = CMD_HOLD;
    cmd_ready     = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          step_next     = '0;
          state_next    = ST_DONE;
          res_data_next = '0;
          res_ok_next   = 1'b0;
          unique case (op_t'(opcode))
            OP_APPEND: begin
              if (count != CNT_W'(CAPACITY)) begin
                cell_cmd    = CMD_APPEND;
                count_next  = count + CNT_W'(1);
                res_ok_next = 1'b1;
              end
            end
            OP_REMOVE_LAST: begin
              if (count == '0) begin
                res_data_next = FCV_FAIL_DATA;
              end else begin
                target_next = last;
                pop_next    = 1'b1;
                state_next  = ST_ROTATE;
              end
            end
            OP_READ: begin
              if (CNT_W'(position) >= count) begin
                res_data_next = FCV_FAIL_DATA;
              end else begin
                target_next = position;
                pop_next    = 1'b0;
                state_next  = ST_ROTATE;
              end
            end
            OP_DELETE: begin
              if (CNT_W'(position) < count) begin
                cell_cmd    = CMD_DELETE;
                count_next  = count_dec;
                res_ok_next = 1'b1;
              end
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_ROTATE: begin
        // the head cell holds word number step during this cycle
        cell_cmd  = CMD_ROTATE;
        step_next = step + IDX_W'(1);
        if (step == target) begin
          res_data_next = head_data;
          res_ok_next   = 1'b1;
        end
        if (step == last) begin
          state_next = ST_DONE;
          if (pop) begin
            count_next = count_dec;
          end
        end
      end
      ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Work and output registers
  always_ff @(posedge clk) begin
    step     <= step_next;
    target   <= target_next;
    pop      <= pop_next;
    res_data <= res_data_next;
    res_ok   <= res_ok_next;
    if (load_out) begin
      read_data  <= res_data;
      done_ok    <= res_ok;
      item_count <= count;
    end
  end

endmodule

>>> hdl/fcv_checker.sv
module fcv_checker #(
  parameter int CAPACITY = fcv_pkg::FCV_CAPACITY
) (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   rsp_valid,
  input logic                                   rsp_ready,
  input logic signed [fcv_pkg::FCV_DATA_W-1:0]  read_data,
  input logic                                   done_ok,
  input logic [$clog2(CAPACITY+1)-1:0]          item_count
);
  import fcv_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] prev_count;

  // Track the fill count of the last transferred result
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_count <= '0;
    end else if (rsp_valid && rsp_ready) begin
      prev_count <= item_count;
    end
  end

  // Fill count never exceeds the capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> item_count <= CNT_W'(CAPACITY))
    else $error("item_count above capacity");

  // A failed operation reports zero or the failure word
  a_fail_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !done_ok |-> (read_data == '0 || read_data == FCV_FAIL_DATA))
    else $error("failed result carries an unexpected word");

  // Consecutive results differ in fill count by at most one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready |-> (item_count == prev_count ||
                                item_count == prev_count + CNT_W'(1) ||
                                item_count == prev_count - CNT_W'(1)))
    else $error("fill count jumped between results");

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data) &&
                                $stable(done_ok) && $stable(item_count))
    else $error("result changed while stalled");

endmodule

bind fixed_capacity_vector fcv_checker #(.CAPACITY(CAPACITY)) u_fcv_checker (.*);
